/* sv/rtfp_pkg.sv */
// Package for the radar target frame parser.
// Holds the frame constants and the slot and frame types shared by all modules.
// No dependencies.
`default_nettype none

package rtfp_pkg;

	localparam int WinLen     = 30;
	localparam int FillW      = 5;
	localparam int DataOfs    = 4;
	localparam int SlotStride = 8;
	localparam int NumTargets = 3;
	localparam int MaxSlots   = 3;
	localparam int NumSlots   = (NumTargets > MaxSlots) ? MaxSlots : NumTargets;
	localparam int SlotW      = 2;
	localparam int CountW     = 2;

	localparam logic [7:0] HdrByte0 = 8'hAA;
	localparam logic [7:0] HdrByte1 = 8'hFF;
	localparam logic [7:0] HdrByte2 = 8'h03;
	localparam logic [7:0] HdrByte3 = 8'h00;
	localparam logic [7:0] FtrByte0 = 8'h55;
	localparam logic [7:0] FtrByte1 = 8'hCC;

	localparam logic [FillW-1:0] FillFull = FillW'(WinLen);
	localparam logic [FillW-1:0] FillNear = FillW'(WinLen - 1);
	localparam logic [SlotW-1:0] LastSlot = SlotW'(NumSlots - 1);

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic signed [15:0] x_mm;
		logic signed [15:0] y_mm;
		logic signed [15:0] radial_speed;
		logic [15:0]        resolution;
		logic               present;
	} slot_t;

	typedef struct packed {
		logic                       load;
		slot_t [NumSlots-1:0]       slots;
		logic [CountW-1:0]          present_count;
	} frame_t;

endpackage

`default_nettype wire

/* sv/rtfp_window.sv */
// Sliding byte window, fill counter and frame detector of the radar frame parser.
// Depends on rtfp_pkg.
`default_nettype none

module rtfp_window
	import rtfp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  accept,
	input  wire byte_t in_byte,
	output logic       near_full,
	output frame_t     frame
);

	byte_t            win_q [WinLen];
	byte_t            win_nx [WinLen];
	logic [FillW-1:0] fill_q;
	logic [FillW-1:0] fill_nx;
	logic             hdr_ok;
	logic             ftr_ok;
	logic [CountW-1:0] cnt;

	always_comb begin
		for (int i = 0; i < WinLen - 1; i++) begin
			win_nx[i] = win_q[i+1];
		end
		win_nx[WinLen-1] = in_byte;
		fill_nx = (fill_q == FillFull) ? FillFull : fill_q + FillW'(1);
	end

	assign hdr_ok = (win_nx[0] == HdrByte0) && (win_nx[1] == HdrByte1) &&
			(win_nx[2] == HdrByte2) && (win_nx[3] == HdrByte3);
	assign ftr_ok = (win_nx[WinLen-2] == FtrByte0) && (win_nx[WinLen-1] == FtrByte1);

	always_comb begin
		cnt = '0;
		for (int t = 0; t < NumSlots; t++) begin
			frame.slots[t].x_mm = {win_nx[DataOfs + t*SlotStride + 1],
					win_nx[DataOfs + t*SlotStride]};
			frame.slots[t].y_mm = {win_nx[DataOfs + t*SlotStride + 3],
					win_nx[DataOfs + t*SlotStride + 2]};
			frame.slots[t].radial_speed = {win_nx[DataOfs + t*SlotStride + 5],
					win_nx[DataOfs + t*SlotStride + 4]};
			frame.slots[t].resolution = {win_nx[DataOfs + t*SlotStride + 7],
					win_nx[DataOfs + t*SlotStride + 6]};
			frame.slots[t].present = (frame.slots[t].y_mm > 16'sd0);
			cnt = cnt + CountW'(frame.slots[t].present);
		end
		frame.present_count = cnt;
		frame.load = accept && (fill_nx == FillFull) && hdr_ok && ftr_ok;
	end

	// A frame can complete on the next byte only once this many bytes are in.
	assign near_full = (fill_q >= FillNear);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < WinLen; i++) begin
				win_q[i] <= '0;
			end
		end else if (accept) begin
			win_q  <= win_nx;
			fill_q <= frame.load ? '0 : fill_nx;
		end
	end

`ifndef SYNTH
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FillFull)
		else $error("fill count beyond window length");
	a_load_needs_fill: assert property (@(posedge clk) disable iff (!arst_n)
		frame.load |-> near_full)
		else $error("frame detected before window filled");
	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		frame.load |=> (fill_q == '0))
		else $error("fill count not cleared after frame");
`endif

endmodule

`default_nettype wire

/* sv/rtfp_emit.sv */
// Frame buffer and result sequencer of the radar frame parser: sends one target
// slot per cycle into the output register while it is free. Depends on rtfp_pkg.
`default_nettype none

module rtfp_emit
	import rtfp_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire frame_t        frame,
	output logic               busy,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [SlotW-1:0]   out_slot,
	output slot_t              out_data,
	output logic [CountW-1:0]  out_count,
	output logic               out_last
);

	slot_t             buf_q [NumSlots];
	logic [CountW-1:0] cnt_q;
	logic              busy_q;
	logic [SlotW-1:0]  slot_q;
	logic              out_valid_q;
	logic [SlotW-1:0]  out_slot_q;
	slot_t             out_data_q;
	logic [CountW-1:0] out_count_q;
	logic              out_last_q;
	logic              out_free;
	logic              send;

	assign out_free = !out_valid_q || out_ready;
	assign send     = busy_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (frame.load) begin
				busy_q <= 1'b1;
				slot_q <= '0;
			end else if (send) begin
				slot_q <= slot_q + SlotW'(1);
				if (slot_q == LastSlot) begin
					busy_q <= 1'b0;
				end
			end
			if (send) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame.load) begin
			for (int t = 0; t < NumSlots; t++) begin
				buf_q[t] <= frame.slots[t];
			end
			cnt_q <= frame.present_count;
		end
		if (send) begin
			out_slot_q  <= slot_q;
			out_data_q  <= buf_q[slot_q];
			out_count_q <= cnt_q;
			out_last_q  <= (slot_q == LastSlot);
		end
	end

	assign busy      = busy_q;
	assign out_valid = out_valid_q;
	assign out_slot  = out_slot_q;
	assign out_data  = out_data_q;
	assign out_count = out_count_q;
	assign out_last  = out_last_q;

`ifndef SYNTH
	a_load_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		frame.load |-> !busy_q)
		else $error("frame loaded while previous frame still being sent");
	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(send && (slot_q == LastSlot)) |=> (!busy_q && out_valid_q && out_last_q))
		else $error("last slot did not end the frame");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (slot_q <= LastSlot))
		else $error("slot index out of range");
	a_last_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_slot_q == LastSlot))
		else $error("last flag on wrong slot");
`endif

endmodule

`default_nettype wire

/* sv/radar_target_frame_parser_unit.sv */
// Top level of the radar target frame parser.
// Depends on rtfp_pkg, rtfp_window and rtfp_emit.
//
// The slave stream takes one received serial byte per transfer on s_axis_tdata.
// Every byte shifts into a 30-byte window. When at least 30 bytes have arrived
// since the last frame and the window starts with AA FF 03 00 and ends with
// 55 CC, the frame is taken and the byte count starts over.
// For each taken frame the master stream sends three transfers, one per target
// slot, in slot order; tlast marks the third. Each carries x, y, speed and
// resolution of that slot, the present count of the frame in tdata, and the
// slot index and present flag in tuser.
// The transfer of a frame's final byte loads its slots into the frame buffer;
// the sequencer then sends them into the output register one per cycle while
// that register is free. One byte is taken every cycle while s_axis_tready is
// high; a frame occupies the result sequencer until its last slot is sent.
// When the receiver stalls, the output register holds its transfer and the
// block keeps taking bytes; s_axis_tready drops only while results of the
// previous frame are still pending and the next byte could complete a frame.
// Reset clears the window, the byte count and all valid flags; no clearing
// pass is needed and bytes are taken from the first cycle after reset.
`default_nettype none

module radar_target_frame_parser_unit
	import rtfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [71:0]      m_axis_tdata,   // [15:0] x_mm, [31:16] y_mm,
	                                         // [47:32] radial_speed, [63:48] resolution,
	                                         // [65:64] present_count, [71:66] zero
	output logic [2:0]       m_axis_tuser,   // [1:0] target_slot, [2] present
	output logic             m_axis_tlast    // last_slot
);

	logic              accept;
	logic              near_full;
	logic              busy;
	frame_t            frame;
	logic [SlotW-1:0]  out_slot;
	slot_t             out_data;
	logic [CountW-1:0] out_count;

	// Hold off only when a byte could complete a new frame before the old one is out.
	assign s_axis_tready = !(busy && near_full);
	assign accept        = s_axis_tvalid && s_axis_tready;

	rtfp_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (s_axis_tdata),
		.near_full (near_full),
		.frame     (frame)
	);

	rtfp_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame),
		.busy      (busy),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_slot  (out_slot),
		.out_data  (out_data),
		.out_count (out_count),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {6'b0, out_count, out_data.resolution, out_data.radial_speed,
			out_data.y_mm, out_data.x_mm};
	assign m_axis_tuser = {out_data.present, out_slot};

endmodule

`default_nettype wire
